// ----- rtl/ilbd_pkg.sv -----
// Shared constants and codes for the iSAX lower-bound distance core.
// No dependencies; imported by the core module.
`timescale 1ns / 1ps

package ilbd_pkg;

  // Field widths
  localparam int unsigned PaaW    = 32;
  localparam int unsigned MaxBits = 8;
  localparam int unsigned SymW    = MaxBits;
  localparam int unsigned BitsW   = 4;
  localparam int unsigned BoundW  = 16;
  localparam int unsigned RatioW  = 32;
  localparam int unsigned DistW   = 48;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ALIGNED_MODE = 2'd0,
    CFG_LOWER_BOUND  = 2'd1,
    CFG_UPPER_BOUND  = 2'd2,
    CFG_SCALE_RATIO  = 2'd3
  } cfg_idx_e;

  // Quantile table geometry
  localparam int unsigned RomDepth = 255;
  localparam int unsigned RomAw    = 8;
  localparam int unsigned RomW     = 32;
  localparam int unsigned RomMid   = (RomDepth - 1) / 2;
  localparam int unsigned KW       = 9;
  localparam int unsigned KMid     = RomMid + 1;
  localparam int unsigned KFirst   = RomMid + 2;

  // Table build: density recurrence on a 2^-16 grid, Q40 density
  localparam int unsigned GridLimit = 262144;
  localparam int unsigned GridW     = 18;
  localparam int unsigned DensW     = 40;
  localparam int unsigned AreaW     = 58;
  localparam int unsigned UShift    = 20;
  localparam int unsigned TShift    = 33;
  localparam int unsigned VShift    = 47;
  localparam int unsigned TgtShift  = 49;
  localparam logic [DensW-1:0] Density0 = 40'd438641676112;

  // Shared multiplier and accumulator
  localparam int unsigned MulW  = 32;
  localparam int unsigned ProdW = 2 * MulW;
  localparam int unsigned AccW  = 80;

endpackage

// ----- rtl/ilbd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ilbd_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write on request, read every cycle into the output register
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/isax_lower_bound_distance_core.sv -----
// iSAX lower-bound distance core: region lookup, squared gap sum, scaled result.
// Depends on ilbd_pkg and ilbd_ram (quantile breakpoint table).
//
//   channel | dir | handshake               | payload
//   --------+-----+-------------------------+----------------------------------------
//   in      | in  | in_valid_i / in_ready_o | paa_value_i symbol_i symbol_bits_i
//           |     |                         | last_segment_i
//   out     | out | out_valid_o/out_ready_i | distance_o saturated_o
//   cfg     | in  | cfg_valid_i/cfg_ready_o | cfg_index_i cfg_data_i
//
// A segment passes S_RD_UP, S_GAP, S_SQUARE and S_ACCUM before the next transfer;
// a last segment adds S_SCALE0 to S_SCALE2 and S_OUT. The single 32x32 multiplier
// serves the square and two scaling partial products; the breakpoint table is read
// twice through its single read port. After reset the table is built in place, each
// grid step passing S_FILL_T0 to S_FILL_CK, over roughly 174,400 steps plus 2 writes
// per entry; in_ready_o stays low until then. Configuration is taken in any cycle.
// A result waits in the output register; only the next last segment stalls on it.
`timescale 1ns / 1ps

module isax_lower_bound_distance_core
  import ilbd_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Segment input
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [PaaW-1:0]     paa_value_i,
  input  logic        [SymW-1:0]     symbol_i,
  input  logic        [BitsW-1:0]    symbol_bits_i,
  input  logic                       last_segment_i,
  // Distance output
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic        [DistW-1:0]    distance_o,
  output logic                       saturated_o,
  // Configuration writes
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic        [CfgIdxW-1:0]  cfg_index_i,
  input  logic        [CfgDataW-1:0] cfg_data_i
);

  typedef enum logic [4:0] {
    S_FILL_INIT,
    S_FILL_T0,
    S_FILL_T1,
    S_FILL_T2,
    S_FILL_U0,
    S_FILL_U1,
    S_FILL_U2,
    S_FILL_UP,
    S_FILL_CK,
    S_FILL_WM,
    S_IDLE,
    S_RD_UP,
    S_GAP,
    S_SQUARE,
    S_ACCUM,
    S_SCALE0,
    S_SCALE1,
    S_SCALE2,
    S_OUT
  } state_e;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_LOAD,
    ACC_ADD
  } acc_op_e;

  state_e state_q, state_d;

  // Configuration registers
  logic                     aligned_q;
  logic signed [BoundW-1:0] lower_q;
  logic signed [BoundW-1:0] upper_q;
  logic [RatioW-1:0]        ratio_q;

  // Segment datapath
  logic signed [PaaW-1:0] paa_q;
  logic [SymW-1:0]        ru_q;
  logic                   rl_zero_q;
  logic                   ru_full_q;
  logic                   last_q;
  logic signed [PaaW-1:0] bl_q;
  logic [PaaW-1:0]        g_q;
  logic [DistW-1:0]       gap_sum_q;
  logic                   clip_q;

  // Output register
  logic             out_valid_q;
  logic [DistW-1:0] dist_q;
  logic             sat_q;

  // Table build datapath
  logic [DensW-1:0] dens_q;
  logic [AreaW-1:0] area_q;
  logic [GridW-1:0] grid_q;
  logic [KW-1:0]    k_q;
  logic [AreaW-1:0] t_q;
  logic [DensW-1:0] pn_q;
  logic [AreaW-1:0] sp_q;
  logic [RomW-1:0]  x_q;

  // Shared multiplier and accumulator
  logic [MulW-1:0]  mul_a, mul_b;
  acc_op_e          mul_op;
  logic             mul_sh32;
  logic [ProdW-1:0] prod_d, prod_q;
  acc_op_e          op_q;
  logic             sh32_q;
  logic [AccW-1:0]  addend;
  logic [AccW-1:0]  acc_q;

  // Table port
  logic             ram_we;
  logic [RomAw-1:0] ram_waddr;
  logic [RomW-1:0]  ram_wdata;
  logic [RomAw-1:0] ram_raddr;
  logic [RomW-1:0]  ram_rdata;

  // ---------------------------------------------------------------------------
  // Symbol widening to a region at full bit count
  logic [BitsW-1:0] bits_c;
  logic [BitsW-1:0] sh_c;
  logic [SymW:0]    low_w;
  logic [SymW-1:0]  low_c;
  logic [SymW-1:0]  rl_c;
  logic [SymW-1:0]  ru_c;

  always_comb begin
    bits_c = (symbol_bits_i > BitsW'(MaxBits)) ? BitsW'(MaxBits) : symbol_bits_i;
    sh_c   = BitsW'(MaxBits) - bits_c;
    low_w  = ((SymW+1)'(1) << sh_c) - (SymW+1)'(1);
    low_c  = low_w[SymW-1:0];
    rl_c   = aligned_q ? (symbol_i & ~low_c) : (symbol_i << sh_c);
    ru_c   = rl_c | low_c;
  end

  // ---------------------------------------------------------------------------
  // Breakpoints and gap to the region
  logic signed [PaaW-1:0] bl_c, bu_c;
  logic signed [PaaW:0]   dl_c, du_c;
  logic [PaaW-1:0]        g_c;

  always_comb begin
    bl_c = rl_zero_q ? {lower_q, 16'd0} : ram_rdata;
    bu_c = ru_full_q ? {upper_q, 16'd0} : ram_rdata;
    dl_c = {bl_q[PaaW-1], bl_q} - {paa_q[PaaW-1], paa_q};
    du_c = {paa_q[PaaW-1], paa_q} - {bu_c[PaaW-1], bu_c};
    if (dl_c > 33'sd0) begin
      g_c = dl_c[PaaW-1:0];
    end else if (du_c > 33'sd0) begin
      g_c = du_c[PaaW-1:0];
    end else begin
      g_c = '0;
    end
  end

  // Saturating sum and scaled result
  logic [DistW:0]   sum_c;
  logic             over_c;
  logic [DistW-1:0] dist_c;

  always_comb begin
    sum_c  = {1'b0, gap_sum_q} + {1'b0, prod_q[ProdW-1:16]};
    over_c = |acc_q[AccW-1:ProdW];
    dist_c = over_c ? '1 : acc_q[ProdW-1:16];
  end

  // ---------------------------------------------------------------------------
  // Table build arithmetic
  logic [MulW-1:0]  odd_c;
  logic [DensW-1:0] pn_c;
  logic [AreaW-1:0] sn_c;
  logic [AreaW-1:0] tgt_c;
  logic [RomW-1:0]  x_c;
  logic             hit_c;
  logic             fill_end_c;

  always_comb begin
    odd_c      = MulW'({grid_q, 1'b1});
    pn_c       = dens_q - DensW'(t_q >> TShift) + DensW'(acc_q >> VShift);
    sn_c       = sp_q + AreaW'(pn_q);
    tgt_c      = AreaW'(k_q - KW'(KMid)) << TgtShift;
    x_c        = (sp_q >= tgt_c) ? RomW'(grid_q) : RomW'(grid_q) + RomW'(1);
    hit_c      = (k_q <= KW'(RomDepth)) && (sn_c >= tgt_c);
    fill_end_c = (k_q > KW'(RomDepth)) || (grid_q == GridW'(GridLimit - 1));
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state, multiplier issue, table port
  always_comb begin
    state_d   = state_q;
    mul_a     = '0;
    mul_b     = '0;
    mul_op    = ACC_NONE;
    mul_sh32  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = ru_q;
    unique case (state_q)
      S_FILL_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = RomAw'(RomMid);
        state_d   = S_FILL_T0;
      end
      S_FILL_T0: begin
        mul_a   = dens_q[MulW-1:0];
        mul_b   = odd_c;
        mul_op  = ACC_LOAD;
        state_d = S_FILL_T1;
      end
      S_FILL_T1: begin
        mul_a    = MulW'(dens_q >> MulW);
        mul_b    = odd_c;
        mul_op   = ACC_ADD;
        mul_sh32 = 1'b1;
        state_d  = S_FILL_T2;
      end
      S_FILL_T2: state_d = S_FILL_U0;
      S_FILL_U0: begin
        mul_a   = acc_q[UShift +: MulW];
        mul_b   = odd_c;
        mul_op  = ACC_LOAD;
        state_d = S_FILL_U1;
      end
      S_FILL_U1: begin
        mul_a    = MulW'(t_q >> (UShift + MulW));
        mul_b    = odd_c;
        mul_op   = ACC_ADD;
        mul_sh32 = 1'b1;
        state_d  = S_FILL_U2;
      end
      S_FILL_U2: state_d = S_FILL_UP;
      S_FILL_UP: state_d = S_FILL_CK;
      S_FILL_CK: begin
        if (hit_c) begin
          // upper half entry now, mirrored entry next cycle
          ram_we    = 1'b1;
          ram_waddr = RomAw'(k_q - KW'(1));
          ram_wdata = x_c;
          state_d   = S_FILL_WM;
        end else if (fill_end_c) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_FILL_T0;
        end
      end
      S_FILL_WM: begin
        ram_we    = 1'b1;
        ram_waddr = RomAw'(KW'(RomDepth) - k_q);
        ram_wdata = RomW'(0) - x_q;
        state_d   = S_FILL_CK;
      end
      S_IDLE: begin
        ram_raddr = (rl_c == '0) ? '0 : rl_c - SymW'(1);
        if (in_valid_i) begin
          state_d = S_RD_UP;
        end
      end
      S_RD_UP:  state_d = S_GAP;
      S_GAP:    state_d = S_SQUARE;
      S_SQUARE: begin
        mul_a   = g_q;
        mul_b   = g_q;
        state_d = S_ACCUM;
      end
      S_ACCUM:  state_d = last_q ? S_SCALE0 : S_IDLE;
      S_SCALE0: begin
        mul_a   = gap_sum_q[MulW-1:0];
        mul_b   = ratio_q;
        mul_op  = ACC_LOAD;
        state_d = S_SCALE1;
      end
      S_SCALE1: begin
        mul_a    = MulW'(gap_sum_q >> MulW);
        mul_b    = ratio_q;
        mul_op   = ACC_ADD;
        mul_sh32 = 1'b1;
        state_d  = S_SCALE2;
      end
      S_SCALE2: state_d = S_OUT;
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_FILL_INIT;
    endcase
  end

  // State, running sum and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FILL_INIT;
      gap_sum_q   <= '0;
      clip_q      <= 1'b0;
      out_valid_q <= 1'b0;
      dist_q      <= '0;
      sat_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      // add the squared gap, stick at full scale on overflow
      if (state_q == S_ACCUM) begin
        if (sum_c[DistW]) begin
          gap_sum_q <= '1;
          clip_q    <= 1'b1;
        end else begin
          gap_sum_q <= sum_c[DistW-1:0];
        end
      end
      // emit the scaled sum and restart the word, else drop a transferred result
      if (state_q == S_OUT && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
        dist_q      <= dist_c;
        sat_q       <= clip_q | over_c;
        gap_sum_q   <= '0;
        clip_q      <= 1'b0;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aligned_q <= 1'b0;
      lower_q   <= 16'sh8000;
      upper_q   <= 16'sh7FFF;
      ratio_q   <= RatioW'(65536);
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ALIGNED_MODE: aligned_q <= cfg_data_i[0];
        CFG_LOWER_BOUND:  lower_q   <= cfg_data_i[BoundW-1:0];
        CFG_UPPER_BOUND:  upper_q   <= cfg_data_i[BoundW-1:0];
        CFG_SCALE_RATIO:  ratio_q   <= cfg_data_i[RatioW-1:0];
      endcase
    end
  end

  // Datapath registers for segments and for the table build
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_FILL_INIT: begin
        dens_q <= Density0;
        area_q <= '0;
        grid_q <= '0;
        k_q    <= KW'(KFirst);
      end
      S_FILL_U0: t_q <= acc_q[AreaW-1:0];
      S_FILL_UP: begin
        pn_q <= pn_c;
        sp_q <= area_q + AreaW'(dens_q);
      end
      S_FILL_CK: begin
        if (hit_c) begin
          x_q <= x_c;
        end else begin
          // advance one grid step
          dens_q <= pn_q;
          area_q <= sn_c;
          grid_q <= grid_q + GridW'(1);
        end
      end
      S_FILL_WM: k_q <= k_q + KW'(1);
      S_IDLE: begin
        if (in_valid_i) begin
          paa_q     <= paa_value_i;
          ru_q      <= ru_c;
          rl_zero_q <= (rl_c == '0);
          ru_full_q <= (ru_c == '1);
          last_q    <= last_segment_i;
        end
      end
      S_RD_UP: bl_q <= bl_c;
      S_GAP:   g_q  <= g_c;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Shared unit: registered product, then shift and accumulate
  assign prod_d = {{(ProdW-MulW){1'b0}}, mul_a} * {{(ProdW-MulW){1'b0}}, mul_b};
  assign addend = sh32_q ? {prod_q[AccW-MulW-1:0], {MulW{1'b0}}}
                         : {{(AccW-ProdW){1'b0}}, prod_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q   <= ACC_NONE;
      sh32_q <= 1'b0;
    end else begin
      op_q   <= mul_op;
      sh32_q <= mul_sh32;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    case (op_q)
      ACC_LOAD: acc_q <= addend;
      ACC_ADD:  acc_q <= acc_q + addend;
      default:  ;
    endcase
  end

  // Breakpoint table
  ilbd_ram #(
    .Width (RomW),
    .Depth (RomDepth)
  ) u_quantile_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign distance_o  = dist_q;
  assign saturated_o = sat_q;

  // ---------------------------------------------------------------------------
  // Checks
  a_clip_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clip_q |-> (gap_sum_q == '1))
    else $error("clip flag set while the sum is below full scale");

  a_table_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_FILL_INIT || state_q == S_FILL_CK || state_q == S_FILL_WM))
    else $error("breakpoint table written outside the build");

  a_sum_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !in_valid_i) |=> $stable(gap_sum_q))
    else $error("running sum moved without a segment");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_OUT))
    else $error("result raised outside the output step");

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the iSAX lower-bound distance core.
// Depends on ilbd_pkg and the core RTL; holds its own quantile table and distance predictor.
`timescale 1ns / 1ps

module tb;
  import ilbd_pkg::*;

  localparam logic [63:0] DIST_FULL      = 64'hFFFF_FFFF_FFFF;
  localparam int unsigned TOP_REGION     = (1 << MaxBits) - 1;
  localparam int unsigned DRAIN_CYCLES   = 32;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WORD_PHASES    = 6;
  localparam int unsigned SEGS_PER_PHASE = 272;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic             saturated;
  } dist_result_t;

  typedef enum logic { ROW_SEGMENT, ROW_CONFIG } row_kind_e;

  typedef struct {
    row_kind_e           kind;
    logic [PaaW-1:0]     paa;
    logic [SymW-1:0]     sym;
    logic [BitsW-1:0]    bits;
    logic                last;
    bit                  typed;
    dist_result_t        want;
    cfg_idx_e            idx;
    logic [CfgDataW-1:0] data;
  } plan_row_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic signed [PaaW-1:0]     paa_value_i;
  logic        [SymW-1:0]     symbol_i;
  logic        [BitsW-1:0]    symbol_bits_i;
  logic                       last_segment_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic        [DistW-1:0]    distance_o;
  logic                       saturated_o;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  cfg_idx_e                   cfg_index_i;
  logic        [CfgDataW-1:0] cfg_data_i;

  // Predictor state: register copies, running gap sum, breakpoint table
  logic                      mode_aligned;
  logic signed [BoundW-1:0]  bound_lo;
  logic signed [BoundW-1:0]  bound_hi;
  logic        [RatioW-1:0]  ratio_q16;
  logic        [63:0]        gap_total;
  logic                      clip_total;
  int                        quantile_q16 [RomDepth];

  dist_result_t pending_distances [$];
  plan_row_t    directed_plan [$];

  int unsigned mismatches;
  int unsigned segments_sent;
  int unsigned words_sent;
  int unsigned distances_checked;
  int unsigned distances_clipped;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_req;

  isax_lower_bound_distance_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .paa_value_i    (paa_value_i),
    .symbol_i       (symbol_i),
    .symbol_bits_i  (symbol_bits_i),
    .last_segment_i (last_segment_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .distance_o     (distance_o),
    .saturated_o    (saturated_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Stop a hung run
  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // Step the normal density on a 2^-16 grid and place each 1/256 quantile
  function automatic void build_quantile_table();
    logic [63:0] dens;
    logic [63:0] area;
    logic [63:0] odd;
    logic [63:0] prod;
    logic [63:0] dens_next;
    logic [63:0] area_next;
    logic [63:0] target;
    logic [63:0] step;
    int unsigned k;
    int          x;
    for (int i = 0; i < RomDepth; i++) quantile_q16[i] = 0;
    dens = 64'd438641676112;
    area = '0;
    k    = 129;
    for (step = '0; step < 64'd262144 && k <= 255; step++) begin
      odd       = 64'd2 * step + 64'd1;
      prod      = dens * odd;
      dens_next = dens - (prod >> 33) + (((prod >> 20) * odd) >> 47);
      area_next = area + dens + dens_next;
      while (k <= 255 && area_next >= (64'(k - 128) << 49)) begin
        target = 64'(k - 128) << 49;
        x = (area + dens >= target) ? int'(step) : int'(step) + 1;
        quantile_q16[k - 1]   = x;
        quantile_q16[255 - k] = -x;
        k++;
      end
      dens = dens_next;
      area = area_next;
    end
  endfunction

  // Add one segment's squared gap; on a last segment produce the scaled distance
  function automatic logic predict_segment(input logic [PaaW-1:0] paa_raw,
                                           input logic [SymW-1:0] sym,
                                           input logic [BitsW-1:0] bits_in,
                                           input logic last,
                                           output dist_result_t res);
    int unsigned bits;
    int unsigned sh;
    int unsigned low;
    int unsigned rl;
    int unsigned ru;
    longint      paa;
    longint      lo_edge;
    longint      hi_edge;
    logic [63:0] gap;
    logic [63:0] sq;
    logic [63:0] sum;
    logic [63:0] rh;
    logic [63:0] rlo;
    logic [63:0] scaled;
    logic        sat;
    res  = '0;
    paa  = longint'($signed(paa_raw));
    bits = (32'(bits_in) > MaxBits) ? MaxBits : 32'(bits_in);
    sh   = MaxBits - bits;
    low  = (32'd1 << sh) - 32'd1;
    rl   = mode_aligned ? (32'(sym) & ~low & TOP_REGION) : ((32'(sym) << sh) & TOP_REGION);
    ru   = rl | low;
    // Register bounds at the outer edges, table breakpoints inside
    lo_edge = (rl == 0) ? longint'(bound_lo) * 65536 : longint'(quantile_q16[rl - 1]);
    hi_edge = (ru == TOP_REGION) ? longint'(bound_hi) * 65536 : longint'(quantile_q16[ru]);
    gap = '0;
    if (lo_edge > paa) gap = 64'(lo_edge - paa);
    else if (hi_edge < paa) gap = 64'(paa - hi_edge);
    sq  = (gap * gap) >> 16;
    sum = gap_total + sq;
    if (sum > DIST_FULL) begin
      sum        = DIST_FULL;
      clip_total = 1'b1;
    end
    gap_total = sum;
    if (!last) return 1'b0;
    rh  = 64'(ratio_q16[31:16]);
    rlo = 64'(ratio_q16[15:0]);
    sat = clip_total;
    if (rh != 0 && gap_total > DIST_FULL / rh) begin
      scaled = DIST_FULL;
      sat    = 1'b1;
    end else begin
      scaled = gap_total * rh + ((gap_total * rlo) >> 16);
      if (scaled > DIST_FULL) begin
        scaled = DIST_FULL;
        sat    = 1'b1;
      end
    end
    res.distance  = scaled[DistW-1:0];
    res.saturated = sat;
    gap_total     = '0;
    clip_total    = 1'b0;
    return 1'b1;
  endfunction

  function automatic void plan_segment(input logic [PaaW-1:0] paa, input logic [SymW-1:0] sym,
                                       input logic [BitsW-1:0] bits, input logic last,
                                       input bit typed = 1'b0,
                                       input logic [DistW-1:0] want_dist = '0,
                                       input logic sat = 1'b0);
    plan_row_t row;
    row      = '{kind: ROW_SEGMENT, idx: CFG_ALIGNED_MODE, default: '0};
    row.paa  = paa;
    row.sym  = sym;
    row.bits = bits;
    row.last = last;
    row.typed = typed;
    row.want = '{distance: want_dist, saturated: sat};
    directed_plan.push_back(row);
  endfunction

  function automatic void plan_config(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    plan_row_t row;
    row      = '{kind: ROW_CONFIG, idx: CFG_ALIGNED_MODE, default: '0};
    row.idx  = idx;
    row.data = data;
    directed_plan.push_back(row);
  endfunction

  // Offer one segment, hold it until the transfer, then predict at the next falling edge
  task automatic send_segment(input logic [PaaW-1:0] paa, input logic [SymW-1:0] sym,
                              input logic [BitsW-1:0] bits, input logic last,
                              input bit typed, input dist_result_t want);
    int unsigned  gap;
    dist_result_t res;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    paa_value_i    <= paa;
    symbol_i       <= sym;
    symbol_bits_i  <= bits;
    last_segment_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    segments_sent++;
    if (last) words_sent++;
    if (predict_segment(paa, sym, bits, last, res)) begin
      pending_distances.push_back(typed ? want : res);
    end
  endtask

  // Drop valid, drain outstanding distances and let the core finish its segment
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_distances.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write one register; fill bits above the field with noise
  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    logic [CfgDataW-1:0] mask;
    logic [CfgDataW-1:0] data;
    case (idx)
      CFG_ALIGNED_MODE: mask = 32'h0000_0001;
      CFG_LOWER_BOUND,
      CFG_UPPER_BOUND:  mask = 32'h0000_FFFF;
      default:          mask = 32'hFFFF_FFFF;
    endcase
    data = ($urandom() & ~mask) | (value & mask);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_ALIGNED_MODE: mode_aligned = data[0];
      CFG_LOWER_BOUND:  bound_lo     = data[BoundW-1:0];
      CFG_UPPER_BOUND:  bound_hi     = data[BoundW-1:0];
      CFG_SCALE_RATIO:  ratio_q16    = data[RatioW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly well-formed words of random content; the rest broken words and edge values
  task automatic send_random_words(input int unsigned target);
    int unsigned      count;
    int unsigned      len;
    int unsigned      i;
    bit               tidy;
    logic [PaaW-1:0]  paa;
    logic [BitsW-1:0] bits;
    logic             last;
    count = 0;
    while (count < target) begin
      tidy = ($urandom_range(99) < 80);
      len  = tidy ? $urandom_range(8, 1) : $urandom_range(40, 1);
      for (i = 0; i < len; i++) begin
        if (tidy) begin
          paa  = ($urandom_range(3) != 0) ? 32'($urandom_range(1048576)) - 32'd524288
                                          : $urandom();
          bits = 4'($urandom_range(MaxBits, 1));
          last = (i == len - 1);
        end else begin
          case ($urandom_range(4))
            0:       paa = 32'h8000_0000;
            1:       paa = 32'h7FFF_FFFF;
            2:       paa = '0;
            default: paa = $urandom();
          endcase
          bits = 4'($urandom_range(15));
          last = ($urandom_range(3) == 0);
        end
        send_segment(paa, 8'($urandom_range(255)), bits, last, 1'b0, '0);
        count++;
      end
    end
  endtask

  // Check each distance transfer against the oldest prediction
  always @(posedge clk_i) begin : check_distance
    dist_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_distances.size() == 0) begin
        report_mismatch($sformatf("distance %0h with none expected", distance_o));
      end else begin
        want = pending_distances.pop_front();
        distances_checked++;
        if (want.saturated) distances_clipped++;
        if (distance_o !== want.distance)
          report_mismatch($sformatf("distance %0h, expected %0h", distance_o, want.distance));
        if (saturated_o !== want.saturated)
          report_mismatch($sformatf("saturated %0b, expected %0b", saturated_o,
                                    want.saturated));
      end
    end
  end

  // Drive ready: random stalls, plus one long hold on request
  initial begin : drive_ready
    int unsigned hold_left;
    int unsigned hold_served;
    hold_left   = 0;
    hold_served = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_req != hold_served) begin
        hold_served++;
        hold_left = HOLD_CYCLES - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : stimulus
    plan_row_t   row;
    int unsigned ph;
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    paa_value_i       = '0;
    symbol_i          = '0;
    symbol_bits_i     = '0;
    last_segment_i    = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_index_i       = CFG_ALIGNED_MODE;
    cfg_data_i        = '0;
    mismatches        = 0;
    segments_sent     = 0;
    words_sent        = 0;
    distances_checked = 0;
    distances_clipped = 0;
    send_idle_pct     = 26;
    recv_idle_pct     = 72;
    hold_req          = 0;
    mode_aligned      = 1'b0;
    bound_lo          = 16'sh8000;
    bound_hi          = 16'sh7FFF;
    ratio_q16         = 32'd65536;
    gap_total         = '0;
    clip_total        = 1'b0;
    build_quantile_table();

    // Reset defaults: whole-range region, extreme means, clamped and zero bit counts
    plan_segment(32'h0000_0000, 8'h00, 4'd0, 1'b1, 1'b1, '0, 1'b0);
    plan_segment(32'h7FFF_FFFF, 8'hFF, 4'd8, 1'b0);
    plan_segment(32'h8000_0000, 8'h00, 4'd8, 1'b1);
    plan_segment(32'h0001_2345, 8'hAA, 4'd15, 1'b0);
    plan_segment(32'hFFFF_0000, 8'h01, 4'd1, 1'b0);
    plan_segment(32'h0003_0000, 8'h0F, 4'd4, 1'b0);
    plan_segment(32'hFFFD_0000, 8'h7F, 4'd7, 1'b1);
    plan_segment(32'h5555_5555, 8'hFF, 4'd0, 1'b1);
    // Symbol bits beyond the widened width are dropped
    plan_segment(32'hAAAA_AAAA, 8'hF8, 4'd3, 1'b1);
    // Masked symbols with crossed bounds; two full-range gaps clip the sum
    plan_config(CFG_ALIGNED_MODE, 32'd1);
    plan_config(CFG_LOWER_BOUND, 32'h0000_7FFF);
    plan_config(CFG_UPPER_BOUND, 32'h0000_8000);
    plan_segment(32'h0000_0000, 8'h00, 4'd0, 1'b0);
    plan_segment(32'h7FFF_FFFF, 8'hC3, 4'd2, 1'b1);
    plan_segment(32'h0000_0000, 8'h80, 4'd8, 1'b0);
    plan_segment(32'h8000_0000, 8'h00, 4'd1, 1'b0);
    plan_segment(32'h8000_0000, 8'h00, 4'd1, 1'b1, 1'b1, DistW'(DIST_FULL), 1'b1);
    // Full ratio clips the scaling
    plan_config(CFG_ALIGNED_MODE, 32'd0);
    plan_config(CFG_LOWER_BOUND, 32'h0000_8000);
    plan_config(CFG_UPPER_BOUND, 32'h0000_7FFF);
    plan_config(CFG_SCALE_RATIO, 32'hFFFF_FFFF);
    plan_segment(32'h8000_0000, 8'hFF, 4'd8, 1'b1, 1'b1, DistW'(DIST_FULL), 1'b1);
    // Zero ratio gives zero
    plan_config(CFG_SCALE_RATIO, 32'd0);
    plan_segment(32'h7FFF_FFFF, 8'h00, 4'd8, 1'b1, 1'b1, '0, 1'b0);
    plan_config(CFG_SCALE_RATIO, 32'h0001_8000);
    plan_segment(32'h0002_0000, 8'h40, 4'd2, 1'b1);

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table
    foreach (directed_plan[n]) begin
      row = directed_plan[n];
      if (row.kind == ROW_CONFIG) begin
        settle();
        write_reg(row.idx, row.data);
      end else begin
        send_segment(row.paa, row.sym, row.bits, row.last, row.typed, row.want);
      end
    end

    // Random words under a sweep of register settings and idle patterns
    for (ph = 0; ph < WORD_PHASES; ph++) begin
      settle();
      if (ph < 2) begin
        send_idle_pct = 26;
        recv_idle_pct = 72;
      end else if (ph < 4) begin
        send_idle_pct = 72;
        recv_idle_pct = 26;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (ph)
        0: begin
          write_reg(CFG_ALIGNED_MODE, 32'd0);
          write_reg(CFG_LOWER_BOUND, 32'h0000_8000);
          write_reg(CFG_UPPER_BOUND, 32'h0000_7FFF);
          write_reg(CFG_SCALE_RATIO, 32'd65536);
        end
        1: begin
          write_reg(CFG_ALIGNED_MODE, 32'd1);
          write_reg(CFG_LOWER_BOUND, 32'(-int'($urandom_range(4))));
          write_reg(CFG_UPPER_BOUND, 32'($urandom_range(4)));
          write_reg(CFG_SCALE_RATIO, 32'($urandom_range(1 << 20)));
        end
        2: begin
          write_reg(CFG_ALIGNED_MODE, 32'd0);
          write_reg(CFG_LOWER_BOUND, 32'h0000_7FFF);
          write_reg(CFG_UPPER_BOUND, 32'h0000_8000);
          write_reg(CFG_SCALE_RATIO, 32'hFFFF_FFFF);
        end
        3: begin
          write_reg(CFG_ALIGNED_MODE, 32'd1);
          write_reg(CFG_LOWER_BOUND, 32'd0);
          write_reg(CFG_UPPER_BOUND, 32'd0);
          write_reg(CFG_SCALE_RATIO, 32'd0);
        end
        4: begin
          write_reg(CFG_ALIGNED_MODE, $urandom());
          write_reg(CFG_LOWER_BOUND, $urandom());
          write_reg(CFG_UPPER_BOUND, $urandom());
          write_reg(CFG_SCALE_RATIO, $urandom());
        end
        default: begin
          write_reg(CFG_ALIGNED_MODE, 32'd0);
          write_reg(CFG_LOWER_BOUND, 32'h0000_FFFF);
          write_reg(CFG_UPPER_BOUND, 32'd1);
          write_reg(CFG_SCALE_RATIO, 32'h0000_8000);
        end
      endcase
      // Hold the output long enough to back up the input
      if (ph == 4) hold_req++;
      send_random_words(SEGS_PER_PHASE);
    end

    settle();
    $display("Ran %0d segments in %0d words; %0d distances checked, %0d saturated.",
             segments_sent, words_sent, distances_checked, distances_clipped);
    $display("Swept shift and mask modes, crossed and extreme bounds, ratios from 0 to max.");
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- isax_lower_bound_distance_core.f -----
rtl/ilbd_pkg.sv
rtl/ilbd_ram.sv
rtl/isax_lower_bound_distance_core.sv
tb/sv/tb.sv
